// ===== hw/rtl/ctg_pkg.sv =====
// ----------------------------------------------------------------------------
// ctg_pkg
// Shared types, register codes and constant tables of the circular
// trajectory generator (CORDIC gain and arctangent tables).
// ----------------------------------------------------------------------------
package ctg_pkg;

	// width of the signed CORDIC angle residue (2^-32 turn units)
	localparam int Z_W = 33;
	// width of the gain and arctangent table entries
	localparam int TAB_W = 30;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_RADIUS       = 2'd0,
		REG_PHASE_STEP   = 2'd1,
		REG_START_PHASE  = 2'd2,
		REG_SAMPLE_COUNT = 2'd3
	} ctg_reg_t;

	// quadrant of the phase, taken from its two top bits
	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} ctg_quad_t;

	// configuration register set
	typedef struct packed {
		logic [15:0] radius;
		logic [31:0] phase_step;
		logic [31:0] start_phase;
		logic [15:0] sample_count;
	} ctg_cfg_t;

	// side information that travels along the chain with each point
	typedef struct packed {
		ctg_quad_t   quad;
		logic [15:0] index;
		logic        last;
	} ctg_tag_t;

	// CORDIC gain K(n) * 2^30 for n = 8..24 iterations
	localparam logic [TAB_W-1:0] GAIN_Q30 [17] = '{
		30'd652039507, 30'd652034532, 30'd652033289, 30'd652032978,
		30'd652032900, 30'd652032880, 30'd652032876, 30'd652032874,
		30'd652032874, 30'd652032874, 30'd652032874, 30'd652032874,
		30'd652032874, 30'd652032874, 30'd652032874, 30'd652032874,
		30'd652032874
	};

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [TAB_W-1:0] ATAN_TURNS [24] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861,
		30'd10430,     30'd5215,      30'd2608,      30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81
	};

	function automatic logic [TAB_W-1:0] gain_q30(input int n);
		return GAIN_Q30[n - 8];
	endfunction

	function automatic logic [TAB_W-1:0] atan_turn(input int i);
		return ATAN_TURNS[i];
	endfunction

endpackage

// ===== hw/rtl/ctg_phase_seq.sv =====
// ----------------------------------------------------------------------------
// ctg_phase_seq
// Phase accumulator and point counter. Picks the phase of each accepted
// tick, marks the last point of the run and loads the gain-scaled start
// vector for the CORDIC chain.
// ----------------------------------------------------------------------------
module ctg_phase_seq
	import ctg_pkg::*;
#(
	parameter int CORDIC_STAGES = 16,
	parameter int PHASE_BITS    = 32,
	parameter int DATA_BITS     = 16,
	parameter int W             = 35
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ce,
	input  logic                in_valid,
	input  logic                restart,
	input  ctg_cfg_t            cfg,
	output logic                valid_s1,
	output logic signed [W-1:0] x_s1,
	output logic signed [Z_W-1:0] z_s1,
	output ctg_tag_t            tag_s1
);

	localparam int PROD_W = 16 + TAB_W;
	localparam logic [TAB_W-1:0] GAIN = gain_q30(CORDIC_STAGES);

	logic [15:0]           counter_q;
	logic [PHASE_BITS-1:0] acc_q;
	logic [PHASE_BITS-1:0] start_acc;
	logic [PHASE_BITS-1:0] step_acc;
	logic [PHASE_BITS-1:0] acc_now;
	logic [31:0]           turn32;
	logic                  accept;
	logic                  begin_run;
	logic [15:0]           cnt;
	logic [15:0]           count_eff;
	logic                  last;
	logic [PROD_W-1:0]     prod;

	// align the 32-bit phase registers to the accumulator and back
	generate
		if (PHASE_BITS >= 32) begin : g_wide
			if (PHASE_BITS > 32) begin : g_pad
				assign start_acc = {cfg.start_phase, {(PHASE_BITS-32){1'b0}}};
				assign step_acc  = {cfg.phase_step, {(PHASE_BITS-32){1'b0}}};
			end else begin : g_same
				assign start_acc = cfg.start_phase;
				assign step_acc  = cfg.phase_step;
			end
			assign turn32 = acc_now[PHASE_BITS-1 -: 32];
		end else begin : g_narrow
			assign start_acc = cfg.start_phase[31 -: PHASE_BITS];
			assign step_acc  = cfg.phase_step[31 -: PHASE_BITS];
			assign turn32    = {acc_now, {(32-PHASE_BITS){1'b0}}};
		end
	endgenerate

	// point selection for this tick
	assign accept    = in_valid & ce;
	assign begin_run = restart | (counter_q == '0);
	assign cnt       = begin_run ? '0 : counter_q;
	assign acc_now   = begin_run ? start_acc : acc_q;
	assign count_eff = (cfg.sample_count == '0) ? 16'd1 : cfg.sample_count;
	assign last      = ({1'b0, cnt} + 17'd1) >= {1'b0, count_eff};

	// gain-compensated start vector
	assign prod = {{TAB_W{1'b0}}, cfg.radius} * {16'b0, GAIN};

	// accumulator and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			acc_q     <= '0;
		end else if (accept) begin
			if (last) begin
				counter_q <= '0;
				acc_q     <= start_acc;
			end else begin
				counter_q <= cnt + 16'd1;
				acc_q     <= acc_now + step_acc;
			end
		end
	end

	// chain entry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			x_s1         <= W'(prod >> (30 - DATA_BITS));
			z_s1         <= {3'b0, turn32[29:0]};
			tag_s1.quad  <= ctg_quad_t'(turn32[31:30]);
			tag_s1.index <= cnt;
			tag_s1.last  <= last;
		end
	end

	// a last point sends the counter back to the start of a run
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> counter_q == '0)
		else $error("counter not cleared after last point");

	// a point that is not last advances the counter by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last |=> counter_q == $past(cnt) + 16'd1)
		else $error("counter did not advance");

	// a restart always issues point zero
	a_restart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && restart |=> valid_s1 && tag_s1.index == '0)
		else $error("restart did not begin at index zero");

endmodule

// ===== hw/rtl/ctg_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// ctg_cordic_cell
// One rotation-mode CORDIC iteration with its register. Rotates the vector
// by +/- atan(2^-STAGE) toward a zero angle residue and passes the point on.
// ----------------------------------------------------------------------------
module ctg_cordic_cell
	import ctg_pkg::*;
#(
	parameter int STAGE = 0,
	parameter int W     = 35
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ce,
	input  logic                  valid_in,
	input  logic signed [W-1:0]   x_in,
	input  logic signed [W-1:0]   y_in,
	input  logic signed [Z_W-1:0] z_in,
	input  ctg_tag_t              tag_in,
	output logic                  valid_q,
	output logic signed [W-1:0]   x_q,
	output logic signed [W-1:0]   y_q,
	output logic signed [Z_W-1:0] z_q,
	output ctg_tag_t              tag_q
);

	localparam logic signed [Z_W-1:0] ANGLE = {{(Z_W-TAB_W){1'b0}}, atan_turn(STAGE)};

	logic signed [W-1:0] dx;
	logic signed [W-1:0] dy;
	logic                pos;

	// floor shifts of the cross terms
	assign dx  = y_in >>> STAGE;
	assign dy  = x_in >>> STAGE;
	assign pos = ~z_in[Z_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ce) begin
			valid_q <= valid_in;
		end
	end

	// micro-rotation
	always_ff @(posedge clk) begin
		if (ce) begin
			if (pos) begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - ANGLE;
			end else begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + ANGLE;
			end
			tag_q <= tag_in;
		end
	end

endmodule

// ===== hw/rtl/circular_trajectory_generator.sv =====
// ----------------------------------------------------------------------------
// circular_trajectory_generator
// Points of uniform circular motion from a phase accumulator and a chain of
// CORDIC cells, one point per tick transaction.
//
//  channel  dir  handshake               payload
//  s_*      in   s_tvalid / s_tready     s_tdata[0] restart
//  m_*      out  m_tvalid / m_tready     m_tdata x_pos, y_pos, sample_index; m_tlast
//  apb      in   psel, penable, pwrite   paddr, pwdata, prdata (4 registers)
//
// One point per clock while the output is not stalled; a point passes the
// entry register, one cell per CORDIC iteration and the rounding output register.
// The whole chain advances together: while the output holds an untaken
// transaction, every stage and the input stall.
// Reset (arst_n low) clears all stage valids, the counter and the
// accumulator and loads the register reset values; no clearing pass.
// ----------------------------------------------------------------------------
module circular_trajectory_generator
	import ctg_pkg::*;
#(
	parameter int CORDIC_STAGES = 16,
	parameter int PHASE_BITS    = 32,
	parameter int DATA_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// tick input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
	// point output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [16:0] x_pos, [33:17] y_pos, [49:34] sample_index
	output logic        m_tlast,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int W  = DATA_BITS + 19;
	localparam int RW = W - DATA_BITS;
	localparam int N  = CORDIC_STAGES;
	localparam logic signed [W-1:0]  HALF   = W'(1) << (DATA_BITS - 1);
	localparam logic signed [RW-1:0] SAT_HI = RW'(65535);
	localparam logic signed [RW-1:0] SAT_LO = -SAT_HI;

	ctg_cfg_t              cfg_q;
	ctg_reg_t              reg_sel;
	logic                  ce;
	logic                  valid_c [N+1];
	logic signed [W-1:0]   x_c     [N+1];
	logic signed [W-1:0]   y_c     [N+1];
	logic signed [Z_W-1:0] z_c     [N+1];
	ctg_tag_t              tag_c   [N+1];
	logic signed [W-1:0]   cx;
	logic signed [W-1:0]   cy;
	logic signed [16:0]    x_pos_q;
	logic signed [16:0]    y_pos_q;
	logic [15:0]           index_q;
	logic                  last_q;
	logic                  valid_q;

	function automatic logic signed [16:0] to_q88(input logic signed [W-1:0] v);
		logic signed [W-1:0]  s;
		logic signed [RW-1:0] r;
		s = v + HALF;
		r = s[W-1:DATA_BITS];
		if (r > SAT_HI) begin
			r = SAT_HI;
		end else if (r < SAT_LO) begin
			r = SAT_LO;
		end
		return r[16:0];
	endfunction

	// register port
	assign pready  = 1'b1;
	assign reg_sel = ctg_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius       <= '0;
			cfg_q.phase_step   <= '0;
			cfg_q.start_phase  <= '0;
			cfg_q.sample_count <= 16'd1;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_RADIUS:       cfg_q.radius       <= pwdata[15:0];
				REG_PHASE_STEP:   cfg_q.phase_step   <= pwdata;
				REG_START_PHASE:  cfg_q.start_phase  <= pwdata;
				REG_SAMPLE_COUNT: cfg_q.sample_count <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_RADIUS:       prdata = {16'b0, cfg_q.radius};
			REG_PHASE_STEP:   prdata = cfg_q.phase_step;
			REG_START_PHASE:  prdata = cfg_q.start_phase;
			REG_SAMPLE_COUNT: prdata = {16'b0, cfg_q.sample_count};
			default:          prdata = '0;
		endcase
	end

	// chain advance
	assign ce       = ~valid_q | m_tready;
	assign s_tready = ce;

	// phase sequencer feeds the chain
	ctg_phase_seq #(
		.CORDIC_STAGES (CORDIC_STAGES),
		.PHASE_BITS    (PHASE_BITS),
		.DATA_BITS     (DATA_BITS),
		.W             (W)
	) u_phase_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_valid (s_tvalid),
		.restart  (s_tdata[0]),
		.cfg      (cfg_q),
		.valid_s1 (valid_c[0]),
		.x_s1     (x_c[0]),
		.z_s1     (z_c[0]),
		.tag_s1   (tag_c[0])
	);
	assign y_c[0] = '0;

	// row of CORDIC cells
	for (genvar k = 0; k < N; k++) begin : g_cell
		ctg_cordic_cell #(
			.STAGE (k),
			.W     (W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ce       (ce),
			.valid_in (valid_c[k]),
			.x_in     (x_c[k]),
			.y_in     (y_c[k]),
			.z_in     (z_c[k]),
			.tag_in   (tag_c[k]),
			.valid_q  (valid_c[k+1]),
			.x_q      (x_c[k+1]),
			.y_q      (y_c[k+1]),
			.z_q      (z_c[k+1]),
			.tag_q    (tag_c[k+1])
		);
	end

	// quadrant fold
	always_comb begin
		case (tag_c[N].quad)
			QUAD_I: begin
				cx = x_c[N];
				cy = y_c[N];
			end
			QUAD_II: begin
				cx = -y_c[N];
				cy = x_c[N];
			end
			QUAD_III: begin
				cx = -x_c[N];
				cy = -y_c[N];
			end
			default: begin
				cx = y_c[N];
				cy = -x_c[N];
			end
		endcase
	end

	// rounding and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ce) begin
			valid_q <= valid_c[N];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			x_pos_q <= to_q88(cx);
			y_pos_q <= to_q88(cy);
			index_q <= tag_c[N].index;
			last_q  <= tag_c[N].last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {6'b0, index_q, y_pos_q, x_pos_q};
	assign m_tlast  = last_q;

	// results stay inside the Q8.8 saturation range
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> x_pos_q != 17'h10000 && y_pos_q != 17'h10000)
		else $error("position outside saturation range");

	// a new result only appears when the last cell held a point
	a_rise_from_chain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_c[N]))
		else $error("output valid without a point in the chain");

	// a stalled output freezes the chain, checked at the last cell's valid and x
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(valid_c[N]) && $stable(x_c[N]))
		else $error("chain moved during output stall");

endmodule
